>>> rtl/chol_pkg.sv
package chol_pkg;

  // Stage map of the pipeline (one register stage per entry)
  localparam int unsigned SQ_STEPS   = 24;  // one root bit per stage
  localparam int unsigned DIV_STEPS  = 31;  // one quotient bit per stage

  localparam int unsigned ST_LOAD0   = 0;
  localparam int unsigned ST_SQ0     = ST_LOAD0 + 1;
  localparam int unsigned ST_DSET0   = ST_SQ0 + SQ_STEPS;
  localparam int unsigned ST_DIV0    = ST_DSET0 + 1;
  localparam int unsigned ST_DFIN0   = ST_DIV0 + DIV_STEPS;
  localparam int unsigned ST_MUL1    = ST_DFIN0 + 1;
  localparam int unsigned ST_PIV1    = ST_MUL1 + 1;
  localparam int unsigned ST_SQ1     = ST_PIV1 + 1;
  localparam int unsigned ST_DSET1   = ST_SQ1 + SQ_STEPS;
  localparam int unsigned ST_DIV1    = ST_DSET1 + 1;
  localparam int unsigned ST_DFIN1   = ST_DIV1 + DIV_STEPS;
  localparam int unsigned ST_MUL2    = ST_DFIN1 + 1;
  localparam int unsigned ST_PIV2    = ST_MUL2 + 1;
  localparam int unsigned ST_SQ2     = ST_PIV2 + 1;
  localparam int unsigned ST_FIN     = ST_SQ2 + SQ_STEPS;
  localparam int unsigned NUM_STAGES = ST_FIN + 1;

  // Everything one matrix carries down the pipe
  typedef struct packed {
    logic                    bad;
    logic signed [31:0]      a00;
    logic signed [31:0]      a10;
    logic signed [31:0]      a20;
    logic signed [31:0]      a11;
    logic signed [31:0]      a21;
    logic signed [31:0]      a22;
    logic [47:0]             sx;    // sqrt remainder
    logic [46:0]             sr;    // sqrt partial root
    logic [23:0]             l00;
    logic [23:0]             l11;
    logic [23:0]             l22;
    logic [23:0]             dv;    // divisor
    logic [1:0][23:0]        drem;
    logic [1:0][30:0]        dnum;
    logic [1:0][30:0]        dq;
    logic [1:0]              dneg;
    logic [1:0]              dovf;
    logic signed [31:0]      l10;
    logic signed [31:0]      l20;
    logic signed [31:0]      l21;
    logic signed [63:0]      p10;
    logic signed [63:0]      p12;
    logic signed [63:0]      p22;
    logic signed [63:0]      p21;
    logic signed [48:0]      t21;
    logic signed [47:0]      q22;
  } item_t;

  // Q16.16 product scaled back, truncated toward zero
  function automatic logic signed [47:0] qtrunc(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + (p[63] ? 64'sd65535 : 64'sd0);
    return t[63:16];
  endfunction

  function automatic item_t sq_load(input item_t it, input logic signed [49:0] piv);
    item_t o;
    o = it;
    if (piv[49] || (piv == '0)) begin
      o.bad = 1'b1;
      o.sx  = '0;
    end else begin
      o.sx = {1'b0, piv[30:0], 16'h0};
    end
    o.sr = '0;
    return o;
  endfunction

  function automatic item_t sq_step(input item_t it, input int unsigned i);
    item_t       o;
    logic [47:0] bitv;
    logic [47:0] sum;
    o    = it;
    bitv = 48'(1) << (46 - 2 * i);
    sum  = {1'b0, it.sr} + bitv;
    if (it.sx >= sum) begin
      o.sx = it.sx - sum;
      o.sr = (it.sr >> 1) + bitv[46:0];
    end else begin
      o.sr = it.sr >> 1;
    end
    return o;
  endfunction

  function automatic item_t div_load(input item_t it, input logic ln,
                                     input logic signed [48:0] n);
    item_t       o;
    logic [48:0] mag;
    o   = it;
    mag = n[48] ? 49'(-n) : 49'(n);
    o.dneg[ln] = n[48];
    o.dovf[ln] = (mag[48:15] >= {10'b0, it.dv});
    o.drem[ln] = mag[38:15];
    o.dnum[ln] = {mag[14:0], 16'h0};
    o.dq[ln]   = '0;
    return o;
  endfunction

  function automatic item_t div_step(input item_t it);
    item_t       o;
    logic [24:0] rem2;
    logic [24:0] diff;
    logic        ge;
    o = it;
    for (int l = 0; l < 2; l++) begin
      rem2 = {it.drem[l], it.dnum[l][30]};
      diff = rem2 - {1'b0, it.dv};
      ge   = (rem2 >= {1'b0, it.dv});
      o.drem[l] = ge ? diff[23:0] : rem2[23:0];
      o.dnum[l] = {it.dnum[l][29:0], 1'b0};
      o.dq[l]   = {it.dq[l][29:0], ge};
    end
    return o;
  endfunction

  function automatic logic signed [31:0] div_fin(input item_t it, input logic ln);
    logic [31:0] qv;
    qv = {1'b0, it.dq[ln]};
    if (it.dovf[ln])
      return it.dneg[ln] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    return it.dneg[ln] ? $signed(-qv) : $signed(qv);
  endfunction

  // Work of stage k; k is constant per stage, so only one arm survives
  function automatic item_t stage_fn(input int unsigned k, input item_t it);
    item_t              o;
    logic signed [49:0] piv;
    o   = it;
    piv = '0;
    if (k == ST_LOAD0) begin
      o.bad = 1'b0;
      o     = sq_load(o, 50'(it.a00));
    end else if (k >= ST_SQ0 && k < ST_SQ0 + SQ_STEPS) begin
      o = sq_step(it, k - ST_SQ0);
    end else if (k == ST_DSET0) begin
      o.l00 = it.sr[23:0];
      o.dv  = it.sr[23:0];
      o     = div_load(o, 1'b0, 49'(it.a10));
      o     = div_load(o, 1'b1, 49'(it.a20));
    end else if (k >= ST_DIV0 && k < ST_DIV0 + DIV_STEPS) begin
      o = div_step(it);
    end else if (k == ST_DFIN0) begin
      o.l10 = div_fin(it, 1'b0);
      o.l20 = div_fin(it, 1'b1);
    end else if (k == ST_MUL1) begin
      o.p10 = it.l10 * it.l10;
      o.p12 = it.l10 * it.l20;
      o.p22 = it.l20 * it.l20;
    end else if (k == ST_PIV1) begin
      piv   = 50'(it.a11) - 50'(qtrunc(it.p10));
      o.t21 = 49'(it.a21) - 49'(qtrunc(it.p12));
      o.q22 = qtrunc(it.p22);
      o     = sq_load(o, piv);
    end else if (k >= ST_SQ1 && k < ST_SQ1 + SQ_STEPS) begin
      o = sq_step(it, k - ST_SQ1);
    end else if (k == ST_DSET1) begin
      o.l11 = it.sr[23:0];
      o.dv  = it.sr[23:0];
      o     = div_load(o, 1'b0, it.t21);
    end else if (k >= ST_DIV1 && k < ST_DIV1 + DIV_STEPS) begin
      o = div_step(it);
    end else if (k == ST_DFIN1) begin
      o.l21 = div_fin(it, 1'b0);
    end else if (k == ST_MUL2) begin
      o.p21 = it.l21 * it.l21;
    end else if (k == ST_PIV2) begin
      piv = 50'(it.a22) - 50'(it.q22) - 50'(qtrunc(it.p21));
      o   = sq_load(o, piv);
    end else if (k >= ST_SQ2 && k < ST_SQ2 + SQ_STEPS) begin
      o = sq_step(it, k - ST_SQ2);
    end else if (k == ST_FIN) begin
      o.l22 = it.sr[23:0];
      if (it.bad) begin
        o.l00 = '0;
        o.l10 = '0;
        o.l20 = '0;
        o.l11 = '0;
        o.l21 = '0;
        o.l22 = '0;
      end
    end
    return o;
  endfunction

endpackage

>>> rtl/chol_stage.sv
module chol_stage
  import chol_pkg::*;
#(
  parameter int unsigned STAGE = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  item_t item_i,
  output logic  ready_o,
  output logic  valid_o,
  output item_t item_o,
  input  logic  ready_i
);

  logic  valid_q;
  item_t item_q;

  // Loads when empty or when the stage below takes its content
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= stage_fn(STAGE, item_i);
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> rtl/cholesky_3x3_spd.sv
// Cholesky factor of a symmetric 3x3 matrix, one matrix per transaction.
//
// Input channel: in_valid_i / in_stall_o with the six distinct entries
// a00, a10, a20, a11, a21, a22 (signed Q16.16). Output channel:
// out_valid_o / out_stall_i with l00, l10, l20, l11, l21, l22 and not_pd.
// A transaction completes on a rising edge with valid high and stall low.
//
// Throughput is one matrix per cycle while out_stall_i stays low: the
// chain is three 24-stage square roots (one root bit per stage), two
// 31-stage dividers (one quotient bit per stage, two lanes in the first),
// and registered 32x32 multiplies plus pivot subtracts.
//
// Each stage holds its own valid bit. When the receiver stalls, the last
// stage holds its result and stages above keep filling until every slot is
// full; only then does in_stall_o rise. Nothing is dropped or repeated.
// Reset clears all valid bits; the pipeline is empty and ready at once.
// A non-positive pivot sets not_pd and forces every L output to zero.
module cholesky_3x3_spd
  import chol_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] in_a00_i,
  input  logic signed [31:0] in_a10_i,
  input  logic signed [31:0] in_a20_i,
  input  logic signed [31:0] in_a11_i,
  input  logic signed [31:0] in_a21_i,
  input  logic signed [31:0] in_a22_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [30:0]        out_l00_o,
  output logic signed [31:0] out_l10_o,
  output logic signed [31:0] out_l20_o,
  output logic [30:0]        out_l11_o,
  output logic signed [31:0] out_l21_o,
  output logic [30:0]        out_l22_o,
  output logic               out_not_pd_o
);

  logic  vld [NUM_STAGES];
  logic  rdy [NUM_STAGES];
  item_t itm [NUM_STAGES];
  item_t in_item;

  // Fresh item: only the matrix entries matter, work fields start clear
  always_comb begin
    in_item     = '0;
    in_item.a00 = in_a00_i;
    in_item.a10 = in_a10_i;
    in_item.a20 = in_a20_i;
    in_item.a11 = in_a11_i;
    in_item.a21 = in_a21_i;
    in_item.a22 = in_a22_i;
  end

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    logic  up_valid;
    item_t up_item;
    logic  dn_ready;

    if (k == 0) begin : g_first
      assign up_valid = in_valid_i;
      assign up_item  = in_item;
    end else begin : g_mid
      assign up_valid = vld[k-1];
      assign up_item  = itm[k-1];
    end

    if (k == NUM_STAGES - 1) begin : g_last
      assign dn_ready = !out_stall_i;
    end else begin : g_inner
      assign dn_ready = rdy[k+1];
    end

    chol_stage #(
      .STAGE(k)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (up_valid),
      .item_i  (up_item),
      .ready_o (rdy[k]),
      .valid_o (vld[k]),
      .item_o  (itm[k]),
      .ready_i (dn_ready)
    );
  end

  assign in_stall_o = !rdy[0];

  // Result taken straight from the final stage register
  assign out_valid_o  = vld[NUM_STAGES-1];
  assign out_l00_o    = {7'b0, itm[NUM_STAGES-1].l00};
  assign out_l10_o    = itm[NUM_STAGES-1].l10;
  assign out_l20_o    = itm[NUM_STAGES-1].l20;
  assign out_l11_o    = {7'b0, itm[NUM_STAGES-1].l11};
  assign out_l21_o    = itm[NUM_STAGES-1].l21;
  assign out_l22_o    = {7'b0, itm[NUM_STAGES-1].l22};
  assign out_not_pd_o = itm[NUM_STAGES-1].bad;

  // Flagged matrices come out all zero
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_not_pd_o |->
      out_l00_o == '0 && out_l10_o == '0 && out_l20_o == '0 &&
      out_l11_o == '0 && out_l21_o == '0 && out_l22_o == '0)
    else $error("not_pd result with nonzero factor");

  // Positive pivots give a root of at least 256
  a_diag_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_not_pd_o |->
      out_l00_o != '0 && out_l11_o != '0 && out_l22_o != '0)
    else $error("zero diagonal on a positive definite result");

  // An accepted transaction lands in the first stage
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld[0])
    else $error("accepted transaction lost at pipe entry");

  // Stalled result stays in the last stage
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

endmodule
